[hw/rtl/rjb_pkg.sv]
// ----------------------------------------------------------------------------
// Reorder jitter buffer package
// Item types, status and operation codes, register indexes and helper
// functions shared by the buffer and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package rjb_pkg;

    localparam int RJB_SLOTS = 32;

    localparam int SEQ_W   = 16;
    localparam int TAG_W   = 16;
    localparam int LEN_W   = 12;
    localparam int TIME_W  = 32;
    localparam int WAIT_W  = 16;
    localparam int LATE_W  = 6;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [WAIT_W-1:0] MAX_WAIT_RESET = WAIT_W'(5);
    localparam logic [LATE_W-1:0] MAX_LATE_RESET = LATE_W'(32);

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WAIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LATE = CFG_IDX_W'(1);

    // Operation codes.
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // Result status codes.
    localparam logic [2:0] STATUS_DELIVERED = 3'd0;
    localparam logic [2:0] STATUS_EMPTY     = 3'd1;
    localparam logic [2:0] STATUS_WAITING   = 3'd2;
    localparam logic [2:0] STATUS_ACCEPTED  = 3'd3;
    localparam logic [2:0] STATUS_LATE      = 3'd4;
    localparam logic [2:0] STATUS_DUPLICATE = 3'd5;
    localparam logic [2:0] STATUS_FULL      = 3'd6;

    typedef struct packed {
        logic              func;
        logic [SEQ_W-1:0]  seq_num;
        logic [TAG_W-1:0]  payload_tag;
        logic [LEN_W-1:0]  payload_len;
        logic [TIME_W-1:0] now_time;
    } req_item_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [SEQ_W-1:0] out_seq;
        logic [TAG_W-1:0] out_tag;
        logic [LEN_W-1:0] out_len;
        logic [SEQ_W-1:0] lost_total;
    } rsp_item_t;

    // One held packet as it sits in the slot memory.
    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] arrival;
        logic [TAG_W-1:0]  tag;
        logic [LEN_W-1:0]  len;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    // True when a comes before b in modulo-65536 serial order.
    function automatic logic serial_before(input logic [SEQ_W-1:0] a,
                                           input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] diff;
        diff = a - b;
        return diff[SEQ_W-1];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/rjb_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rjb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/reorder_jitter_buffer.sv]
// ----------------------------------------------------------------------------
// Reorder jitter buffer
// Holds sequence-numbered packet handles and delivers them in order.
// ----------------------------------------------------------------------------
// Usage: a request beat carries a push (store a packet handle) or a pop (ask
// for the next packet in sequence). Every request gives exactly one response
// beat with a status, the delivered packet on a delivery, and the running
// loss count. Registers max_wait_ms and max_late are written on the cfg
// channel, which is always ready; write them only while the buffer is idle.
// Held packets live in a SLOTS-deep slot memory in order of arrival. Every
// request is handled by one sequencer that walks that memory with a single
// read port, one slot per cycle: a scan finds the wanted sequence, the oldest
// sequence and the earliest arrival, and a delivery then shifts the later
// slots down by one, again one slot per cycle.
// Late drops and empty pops skip the scan and go straight to the S_DONE
// state. A new request is taken only once the previous response sits in
// the output register, which then waits there as long as rsp_stall stays
// high.
// Reset empties the buffer, clears the expected sequence and the loss count,
// and loads max_wait_ms = 5 and max_late = 32. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module reorder_jitter_buffer #(
    parameter int SLOTS = rjb_pkg::RJB_SLOTS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    output logic                                  req_stall,
    input  wire rjb_pkg::req_item_t               req_item,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_stall,
    output rjb_pkg::rsp_item_t                    rsp_item,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [rjb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rjb_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW   = $clog2(SLOTS + 1);
    localparam int CMPW = (CW > rjb_pkg::LATE_W) ? CW : rjb_pkg::LATE_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    // Control state.
    state_t                        state_reg, state_next;
    logic                          exp_valid_reg, exp_valid_next;
    logic [rjb_pkg::SEQ_W-1:0]     exp_reg, exp_next;
    logic [rjb_pkg::SEQ_W-1:0]     loss_reg, loss_next;
    logic [CW-1:0]                 held_reg, held_next;
    logic [rjb_pkg::WAIT_W-1:0]    max_wait_reg, max_wait_next;
    logic [rjb_pkg::LATE_W-1:0]    max_late_reg, max_late_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    logic                          pend_reg, pend_next;
    logic                          found_reg, found_next;

    // Working payload.
    logic                          func_reg, func_next;
    logic [rjb_pkg::SEQ_W-1:0]     key_reg, key_next;
    logic [rjb_pkg::TAG_W-1:0]     tag_reg, tag_next;
    logic [rjb_pkg::LEN_W-1:0]     len_reg, len_next;
    logic [rjb_pkg::TIME_W-1:0]    now_reg, now_next;
    logic [CW-1:0]                 ptr_reg, ptr_next;
    logic [IW-1:0]                 pend_idx_reg, pend_idx_next;
    logic [IW-1:0]                 found_idx_reg, found_idx_next;
    logic [rjb_pkg::TAG_W-1:0]     found_tag_reg, found_tag_next;
    logic [rjb_pkg::LEN_W-1:0]     found_len_reg, found_len_next;
    logic [rjb_pkg::SEQ_W-1:0]     oldest_reg, oldest_next;
    logic [IW-1:0]                 oldest_idx_reg, oldest_idx_next;
    logic [rjb_pkg::TAG_W-1:0]     oldest_tag_reg, oldest_tag_next;
    logic [rjb_pkg::LEN_W-1:0]     oldest_len_reg, oldest_len_next;
    logic [rjb_pkg::TIME_W-1:0]    first_arr_reg, first_arr_next;
    rjb_pkg::rsp_item_t            res_reg, res_next;
    rjb_pkg::rsp_item_t            rsp_item_reg, rsp_item_next;

    // Slot memory port.
    logic                          ram_we;
    logic [IW-1:0]                 ram_waddr;
    rjb_pkg::slot_t                ram_wdata;
    logic [IW-1:0]                 ram_raddr;
    logic [rjb_pkg::SLOT_W-1:0]    ram_rdata_raw;
    rjb_pkg::slot_t                rd_slot;

    logic                          issue_ok;
    logic [rjb_pkg::TIME_W-1:0]    waited;
    logic                          time_ok;
    logic                          count_ok;

    assign rd_slot  = rjb_pkg::slot_t'(ram_rdata_raw);
    assign issue_ok = (ptr_reg < held_reg);
    assign waited   = now_reg - first_arr_reg;
    assign time_ok  = (waited < {{(rjb_pkg::TIME_W - rjb_pkg::WAIT_W){1'b0}}, max_wait_reg});
    assign count_ok = (CMPW'(held_reg) < CMPW'(max_late_reg));

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;
    assign cfg_ready = 1'b1;

    rjb_ram #(
        .WIDTH (rjb_pkg::SLOT_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    always_comb
    begin
        state_next      = state_reg;
        exp_valid_next  = exp_valid_reg;
        exp_next        = exp_reg;
        loss_next       = loss_reg;
        held_next       = held_reg;
        max_wait_next   = max_wait_reg;
        max_late_next   = max_late_reg;
        rsp_valid_next  = rsp_valid_reg;
        pend_next       = pend_reg;
        found_next      = found_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        tag_next        = tag_reg;
        len_next        = len_reg;
        now_next        = now_reg;
        ptr_next        = ptr_reg;
        pend_idx_next   = pend_idx_reg;
        found_idx_next  = found_idx_reg;
        found_tag_next  = found_tag_reg;
        found_len_next  = found_len_reg;
        oldest_next     = oldest_reg;
        oldest_idx_next = oldest_idx_reg;
        oldest_tag_next = oldest_tag_reg;
        oldest_len_next = oldest_len_reg;
        first_arr_next  = first_arr_reg;
        res_next        = res_reg;
        rsp_item_next   = rsp_item_reg;

        ram_we          = 1'b0;
        ram_waddr       = held_reg[IW-1:0];
        ram_wdata       = '{seq: key_reg, arrival: now_reg, tag: tag_reg, len: len_reg};
        ram_raddr       = ptr_reg[IW-1:0];

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            case (cfg_index)
                rjb_pkg::CFG_MAX_WAIT: max_wait_next = cfg_data[rjb_pkg::WAIT_W-1:0];
                rjb_pkg::CFG_MAX_LATE: max_late_next = cfg_data[rjb_pkg::LATE_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    func_next  = req_item.func;
                    key_next   = req_item.seq_num;
                    tag_next   = req_item.payload_tag;
                    len_next   = req_item.payload_len;
                    now_next   = req_item.now_time;
                    res_next   = '0;
                    ptr_next   = '0;
                    pend_next  = 1'b0;
                    found_next = 1'b0;
                    if (req_item.func == rjb_pkg::FUNC_PUSH)
                    begin
                        if (!exp_valid_reg)
                        begin
                            exp_next       = req_item.seq_num;
                            exp_valid_next = 1'b1;
                        end
                        // The first push sets the expected sequence, so it is never late.
                        if (exp_valid_reg && rjb_pkg::serial_before(req_item.seq_num, exp_reg))
                        begin
                            res_next.status = rjb_pkg::STATUS_LATE;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else if (held_reg == '0)
                    begin
                        res_next.status = rjb_pkg::STATUS_EMPTY;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        key_next   = exp_reg;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Reads are issued one slot a cycle; the RAM registers each read's data.
                if (issue_ok)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = ptr_reg[IW-1:0];
                    ptr_next      = ptr_reg + CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    if (!found_reg && rd_slot.seq == key_reg)
                    begin
                        found_next     = 1'b1;
                        found_idx_next = pend_idx_reg;
                        found_tag_next = rd_slot.tag;
                        found_len_next = rd_slot.len;
                    end
                    if (pend_idx_reg == '0 || rjb_pkg::serial_before(rd_slot.seq, oldest_reg))
                    begin
                        oldest_next     = rd_slot.seq;
                        oldest_idx_next = pend_idx_reg;
                        oldest_tag_next = rd_slot.tag;
                        oldest_len_next = rd_slot.len;
                    end
                    if (pend_idx_reg == '0 || rd_slot.arrival < first_arr_reg)
                    begin
                        first_arr_next = rd_slot.arrival;
                    end
                end

                if (!issue_ok && !pend_reg)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (func_reg == rjb_pkg::FUNC_PUSH)
                begin
                    state_next = S_DONE;
                    if (found_reg)
                    begin
                        res_next.status = rjb_pkg::STATUS_DUPLICATE;
                    end
                    else if (held_reg == CW'(SLOTS))
                    begin
                        res_next.status = rjb_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        ram_we          = 1'b1;
                        held_next       = held_reg + CW'(1);
                        res_next.status = rjb_pkg::STATUS_ACCEPTED;
                    end
                end
                else if (found_reg)
                begin
                    res_next.status  = rjb_pkg::STATUS_DELIVERED;
                    res_next.out_seq = key_reg;
                    res_next.out_tag = found_tag_reg;
                    res_next.out_len = found_len_reg;
                    exp_next         = exp_reg + rjb_pkg::SEQ_W'(1);
                    ptr_next         = CW'(found_idx_reg) + CW'(1);
                    pend_next        = 1'b0;
                    state_next       = S_SHIFT;
                end
                else if (time_ok && count_ok)
                begin
                    res_next.status = rjb_pkg::STATUS_WAITING;
                    state_next      = S_DONE;
                end
                else
                begin
                    // Skip the gap: everything up to the oldest held sequence is lost.
                    loss_next        = loss_reg + (oldest_reg - exp_reg);
                    res_next.status  = rjb_pkg::STATUS_DELIVERED;
                    res_next.out_seq = oldest_reg;
                    res_next.out_tag = oldest_tag_reg;
                    res_next.out_len = oldest_len_reg;
                    exp_next         = oldest_reg + rjb_pkg::SEQ_W'(1);
                    ptr_next         = CW'(oldest_idx_reg) + CW'(1);
                    pend_next        = 1'b0;
                    state_next       = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                // Move each later slot down by one, keeping the arrival order.
                if (issue_ok)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = ptr_reg[IW-1:0];
                    ptr_next      = ptr_reg + CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_idx_reg - IW'(1);
                    ram_wdata = rd_slot;
                end

                if (!issue_ok && !pend_reg)
                begin
                    held_next  = held_reg - CW'(1);
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_item_next            = res_reg;
                    rsp_item_next.lost_total = loss_reg;
                    rsp_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            exp_valid_reg <= 1'b0;
            exp_reg       <= '0;
            loss_reg      <= '0;
            held_reg      <= '0;
            max_wait_reg  <= rjb_pkg::MAX_WAIT_RESET;
            max_late_reg  <= rjb_pkg::MAX_LATE_RESET;
            rsp_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            exp_valid_reg <= exp_valid_next;
            exp_reg       <= exp_next;
            loss_reg      <= loss_next;
            held_reg      <= held_next;
            max_wait_reg  <= max_wait_next;
            max_late_reg  <= max_late_next;
            rsp_valid_reg <= rsp_valid_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        key_reg        <= key_next;
        tag_reg        <= tag_next;
        len_reg        <= len_next;
        now_reg        <= now_next;
        ptr_reg        <= ptr_next;
        pend_idx_reg   <= pend_idx_next;
        found_idx_reg  <= found_idx_next;
        found_tag_reg  <= found_tag_next;
        found_len_reg  <= found_len_next;
        oldest_reg     <= oldest_next;
        oldest_idx_reg <= oldest_idx_next;
        oldest_tag_reg <= oldest_tag_next;
        oldest_len_reg <= oldest_len_next;
        first_arr_reg  <= first_arr_next;
        res_reg        <= res_next;
        rsp_item_reg   <= rsp_item_next;
    end

endmodule

`default_nettype wire

[hw/rtl/rjb_checker.sv]
// ----------------------------------------------------------------------------
// Reorder jitter buffer checker
// Port-level assertions on the request, response and configuration channels.
// ----------------------------------------------------------------------------
`default_nettype none

module rjb_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             req_valid,
    input wire logic                             req_stall,
    input wire logic                             rsp_valid,
    input wire logic                             rsp_stall,
    input wire rjb_pkg::rsp_item_t               rsp_item,
    input wire logic                             cfg_ready
);

    // A stalled response beat holds its contents.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
        else $error("response beat changed while stalled");

    // One request is worked on at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while the previous one is in progress");

    // A response appears only at the end of a request's processing.
    a_rsp_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("response raised without a request in progress");

    // Only a delivery carries a packet.
    a_no_packet_unless_delivered: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.status != rjb_pkg::STATUS_DELIVERED
            |-> rsp_item.out_seq == '0 && rsp_item.out_tag == '0 && rsp_item.out_len == '0)
        else $error("packet fields set on a response that delivers nothing");

    // The register write channel never pushes back.
    a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind reorder_jitter_buffer rjb_checker u_rjb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item),
    .cfg_ready (cfg_ready)
);

`default_nettype wire
